/* rtl/core/rfir_pkg.sv */
// shared types and constants of the rollback frame input ring
package rfir_pkg;

  localparam int unsigned FRAME_W     = 32;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [CFG_IDX_W-1:0]  CFG_ROLLBACK_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_LOCAL_DELAY    = 4'd1;
  localparam logic [CFG_DATA_W-1:0] ROLLBACK_RESET     = 4'd7;
  localparam logic [CFG_DATA_W-1:0] DELAY_RESET        = 4'd2;

  typedef enum logic [2:0] {
    KIND_INS_REMOTE  = 3'd0,
    KIND_INS_LOCAL   = 3'd1,
    KIND_ADV_CONFIRM = 3'd2,
    KIND_ADV_PLAY    = 3'd3,
    KIND_READ        = 3'd4,
    KIND_SEND_PEND   = 3'd5,
    KIND_SEND_MISSED = 3'd6,
    KIND_INIT_DELAY  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_REJECT  = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic miss_step;
    logic stream_init;
    logic emit_single;
    logic emit_empty;
    logic emit_entry;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  miss_done;
    logic  first_cont;
    logic  out_busy;
    logic  out_last;
  } sts_t;

endpackage

/* rtl/core/rfir_if.sv */
// channel interfaces: input items, result items, register writes
interface rfir_in_if #(parameter int unsigned INPUT_BITS = 16);
  import rfir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [FRAME_W-1:0]    frame_index;
  logic [INPUT_BITS-1:0] input_value;
  modport source (output valid, kind, frame_index, input_value, input ready);
  modport sink (input valid, kind, frame_index, input_value, output ready);
endinterface

interface rfir_out_if #(parameter int unsigned INPUT_BITS = 16);
  import rfir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [INPUT_BITS-1:0] local_value;
  logic [INPUT_BITS-1:0] remote_value;
  logic [FRAME_W-1:0]    item_frame;
  logic [FRAME_W-1:0]    gameplay_frame;
  logic [FRAME_W-1:0]    confirmed_frame;
  logic                  confirm_ready;
  logic                  gameplay_ready;
  logic                  remote_missed;
  logic                  has_data;
  logic                  last;
  modport source (output valid, status, local_value, remote_value, item_frame, gameplay_frame,
                  confirmed_frame, confirm_ready, gameplay_ready, remote_missed, has_data, last,
                  input ready);
  modport sink (input valid, status, local_value, remote_value, item_frame, gameplay_frame,
                confirmed_frame, confirm_ready, gameplay_ready, remote_missed, has_data, last,
                output ready);
endinterface

interface rfir_cfg_if;
  import rfir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/rfir_ram.sv */
// generic single write port ram with registered read
module rfir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/rfir_ctrl.sv */
// sequencer of the frame input ring
module rfir_ctrl import rfir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MISS, S_SINGLE, S_SCHK, S_SRD, S_SEMIT, S_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   stream_q, stream_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    stream_d = stream_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_MISS;
      end
      S_MISS: begin
        cmd_o.miss_step = 1'b1;
        if (sts_i.miss_done) begin
          if (sts_i.kind == KIND_SEND_PEND || sts_i.kind == KIND_SEND_MISSED) begin
            cmd_o.stream_init = 1'b1;
            state_d           = S_SCHK;
          end else begin
            state_d = S_SINGLE;
          end
        end
      end
      S_SINGLE: begin
        cmd_o.emit_single = 1'b1;
        stream_d          = 1'b0;
        state_d           = S_WAIT;
      end
      S_SCHK: begin
        if (sts_i.first_cont) begin
          state_d = S_SRD;
        end else begin
          cmd_o.emit_empty = 1'b1;
          stream_d         = 1'b0;
          state_d          = S_WAIT;
        end
      end
      S_SRD: begin
        state_d = S_SEMIT;
      end
      S_SEMIT: begin
        cmd_o.emit_entry = 1'b1;
        stream_d         = 1'b1;
        state_d          = S_WAIT;
      end
      S_WAIT: begin
        if (!sts_i.out_busy) begin
          state_d = (stream_q && !sts_i.out_last) ? S_SRD : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      stream_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      stream_q <= stream_d;
    end
  end
endmodule

/* rtl/core/rfir_dp.sv */
// ring slots, frame counters, registers and result register
module rfir_dp import rfir_pkg::*; #(
  parameter int unsigned RING_DEPTH   = 16,
  parameter int unsigned INPUT_BITS   = 16,
  parameter int unsigned MISSED_BURST = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            kind_i,
  input  logic [FRAME_W-1:0]    frame_index_i,
  input  logic [INPUT_BITS-1:0] input_value_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  rfir_cfg_if.sink              cfg_i,
  rfir_out_if.source            out_o
);
  localparam int unsigned SW = $clog2(RING_DEPTH);
  localparam int unsigned MW = $clog2(RING_DEPTH + 1);

  function automatic logic [SW-1:0] slot_of(input logic [FRAME_W-1:0] x);
    logic [FRAME_W-1:0] r;
    r = x % FRAME_W'(RING_DEPTH);
    return r[SW-1:0];
  endfunction

  function automatic logic cont(input kind_e k, input logic [FRAME_W-1:0] x,
                                input logic [CNT_W-1:0] n, input logic [FRAME_W-1:0] tp,
                                input logic [FRAME_W-1:0] cf, input logic lvx);
    logic res;
    if (k == KIND_SEND_PEND) begin
      res = (n < CNT_W'(MAX_RESULTS)) && lvx && ((n == '0) || (x <= tp && x >= cf));
    end else begin
      res = (n < CNT_W'(MISSED_BURST)) && lvx && (x < tp)
         && (({1'b0, x} + (FRAME_W+1)'(RING_DEPTH)) > ({1'b0, tp} + (FRAME_W+1)'(1)));
    end
    return res;
  endfunction

  kind_e                 kind_q;
  logic [FRAME_W-1:0]    f_q, cur_q, cur_d, conf_q, conf_d, hl_q, hl_d, hr_q, hr_d, i_q, i_d;
  logic [INPUT_BITS-1:0] v_q;
  logic [CFG_DATA_W-1:0] lim_q, dly_q;
  logic [RING_DEPTH-1:0] lv_q, lv_d, rv_q, rv_d, lok_q, lok_d, rok_q, rok_d;
  status_e               st_q, st_d;
  logic                  rm_q, rm_d;
  logic [MW-1:0]         m_q, m_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic                  ov_q, ov_d;

  logic [FRAME_W-1:0]    top, conf1, ins_f, diff, mfr, i1, start_i;
  logic [SW-1:0]         s_c1, ins_s, clr_s, s_f, s_conf, lraddr, rraddr;
  logic                  fv_c1, can_conf, can_play, in_win, miss_go, emit;
  logic [INPUT_BITS-1:0] lram_rd, rram_rd, lval, rval;
  logic [CNT_W-1:0]      n1;

  assign top      = (hr_q > hl_q) ? hr_q : hl_q;
  assign conf1    = conf_q + FRAME_W'(1);
  assign s_c1     = slot_of(conf1);
  assign fv_c1    = (conf1 <= top) && (conf1 >= conf_q) && lv_q[s_c1] && rv_q[s_c1];
  assign can_conf = fv_c1 && (conf_q < cur_q);
  assign can_play = ({1'b0, cur_q} <= ({1'b0, conf_q} + (FRAME_W+1)'(lim_q)))
                 && lv_q[slot_of(cur_q)];
  assign ins_f    = (kind_q == KIND_INS_LOCAL) ? cur_q + FRAME_W'(dly_q) : f_q;
  assign in_win   = (ins_f >= conf_q) && ((ins_f - conf_q) < FRAME_W'(RING_DEPTH));
  assign ins_s    = slot_of(ins_f);
  assign clr_s    = slot_of(ins_f + FRAME_W'(1));
  assign diff     = cur_q - conf_q - FRAME_W'(1);
  assign mfr      = conf1 + FRAME_W'(m_q);
  assign miss_go  = !can_conf && (cur_q > conf_q) && (FRAME_W'(m_q) < diff)
                 && (m_q < MW'(RING_DEPTH));
  assign i1       = i_q + FRAME_W'(1);
  assign n1       = n_q + CNT_W'(1);
  assign start_i  = (kind_q == KIND_SEND_PEND) ? conf_q : f_q;
  assign s_f      = slot_of(f_q);
  assign s_conf   = slot_of(conf_q);
  assign lraddr   = (kind_q == KIND_SEND_PEND || kind_q == KIND_SEND_MISSED) ? slot_of(i_q) : s_f;
  assign rraddr   = rv_q[s_f] ? s_f : s_conf;
  assign lval     = lok_q[lraddr] ? lram_rd : '0;
  assign rval     = rok_q[rraddr] ? rram_rd : '0;
  assign emit     = cmd_i.emit_single || cmd_i.emit_empty || cmd_i.emit_entry;

  rfir_ram #(.WIDTH(INPUT_BITS), .DEPTH(RING_DEPTH)) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && kind_q == KIND_INS_LOCAL && in_win),
    .waddr_i (ins_s),
    .wdata_i (v_q),
    .raddr_i (lraddr),
    .rdata_o (lram_rd)
  );

  rfir_ram #(.WIDTH(INPUT_BITS), .DEPTH(RING_DEPTH)) u_remote_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && kind_q == KIND_INS_REMOTE && in_win),
    .waddr_i (ins_s),
    .wdata_i (v_q),
    .raddr_i (rraddr),
    .rdata_o (rram_rd)
  );

  always_comb begin
    cur_d  = cur_q;
    conf_d = conf_q;
    hl_d   = hl_q;
    hr_d   = hr_q;
    lv_d   = lv_q;
    rv_d   = rv_q;
    lok_d  = lok_q;
    rok_d  = rok_q;
    st_d   = st_q;
    rm_d   = rm_q;
    m_d    = m_q;
    i_d    = i_q;
    n_d    = n_q;
    if (cmd_i.exec) begin
      m_d  = '0;
      rm_d = 1'b0;
      st_d = ST_DONE;
      unique case (kind_q)
        KIND_INS_REMOTE, KIND_INS_LOCAL: begin
          if (!in_win) begin
            st_d = ST_REJECT;
          end else if (kind_q == KIND_INS_REMOTE) begin
            if (ins_f > hr_q) begin
              if (ins_f > top) begin
                lv_d[clr_s]  = 1'b0;
                rv_d[clr_s]  = 1'b0;
                lok_d[clr_s] = 1'b0;
                rok_d[clr_s] = 1'b0;
              end
              hr_d = ins_f;
            end
            rv_d[ins_s]  = 1'b1;
            rok_d[ins_s] = 1'b1;
          end else begin
            if (ins_f > hl_q) begin
              if (ins_f > top) begin
                lv_d[clr_s]  = 1'b0;
                rv_d[clr_s]  = 1'b0;
                lok_d[clr_s] = 1'b0;
                rok_d[clr_s] = 1'b0;
              end
              hl_d = ins_f;
            end
            lv_d[ins_s]  = 1'b1;
            lok_d[ins_s] = 1'b1;
          end
        end
        KIND_ADV_CONFIRM: begin
          if (fv_c1) conf_d = conf1;
          else st_d = ST_REFUSED;
        end
        KIND_ADV_PLAY: begin
          if (can_play) cur_d = cur_q + FRAME_W'(1);
          else st_d = ST_REFUSED;
        end
        KIND_READ, KIND_SEND_PEND, KIND_SEND_MISSED: begin
        end
        KIND_INIT_DELAY: begin
          for (int s = 0; s < RING_DEPTH; s++) begin
            if (s < int'(dly_q)) lv_d[s] = 1'b1;
          end
          hl_d = FRAME_W'(dly_q);
        end
        default: st_d = ST_DONE;
      endcase
    end
    if (cmd_i.miss_step && miss_go) begin
      rm_d = rm_q | rv_q[slot_of(mfr)];
      m_d  = m_q + MW'(1);
    end
    if (cmd_i.stream_init) begin
      i_d = start_i;
      n_d = '0;
    end
    if (cmd_i.emit_entry) begin
      i_d = i1;
      n_d = n1;
    end
  end

  assign ov_d = emit ? 1'b1 : ((out_o.valid && out_o.ready) ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      conf_q <= '0;
      hl_q   <= '0;
      hr_q   <= '0;
      lv_q   <= '0;
      rv_q   <= '0;
      lok_q  <= '0;
      rok_q  <= '0;
      lim_q  <= ROLLBACK_RESET;
      dly_q  <= DELAY_RESET;
      kind_q <= KIND_INS_REMOTE;
      st_q   <= ST_DONE;
      rm_q   <= 1'b0;
      m_q    <= '0;
      i_q    <= '0;
      n_q    <= '0;
      ov_q   <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      conf_q <= conf_d;
      hl_q   <= hl_d;
      hr_q   <= hr_d;
      lv_q   <= lv_d;
      rv_q   <= rv_d;
      lok_q  <= lok_d;
      rok_q  <= rok_d;
      st_q   <= st_d;
      rm_q   <= rm_d;
      m_q    <= m_d;
      i_q    <= i_d;
      n_q    <= n_d;
      ov_q   <= ov_d;
      if (cmd_i.load) kind_q <= kind_e'(kind_i);
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_ROLLBACK_LIMIT) lim_q <= cfg_i.data;
        else if (cfg_i.index == CFG_LOCAL_DELAY) dly_q <= cfg_i.data;
      end
    end
  end

  logic [1:0]            o_st;
  logic [INPUT_BITS-1:0] o_lv, o_rv;
  logic [FRAME_W-1:0]    o_fr, o_gp, o_cf;
  logic                  o_cr, o_gr, o_rm, o_hd, o_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q <= frame_index_i;
      v_q <= input_value_i;
    end
    if (emit) begin
      o_gp <= cur_q;
      o_cf <= conf_q;
      o_cr <= can_conf;
      o_gr <= can_play;
      o_rm <= rm_q;
    end
    if (cmd_i.emit_single) begin
      o_st   <= st_q;
      o_lv   <= (kind_q == KIND_READ) ? lval : '0;
      o_rv   <= (kind_q == KIND_READ) ? rval : '0;
      o_fr   <= (kind_q == KIND_READ) ? f_q : '0;
      o_hd   <= (kind_q == KIND_READ);
      o_last <= 1'b1;
    end else if (cmd_i.emit_empty) begin
      o_st   <= ST_DONE;
      o_lv   <= '0;
      o_rv   <= '0;
      o_fr   <= start_i;
      o_hd   <= 1'b0;
      o_last <= 1'b1;
    end else if (cmd_i.emit_entry) begin
      o_st   <= ST_DONE;
      o_lv   <= lval;
      o_rv   <= '0;
      o_fr   <= i_q;
      o_hd   <= 1'b1;
      o_last <= !cont(kind_q, i1, n1, top, conf_q, lv_q[slot_of(i1)]);
    end
  end

  assign cfg_i.ready           = 1'b1;
  assign out_o.valid           = ov_q;
  assign out_o.status          = o_st;
  assign out_o.local_value     = o_lv;
  assign out_o.remote_value    = o_rv;
  assign out_o.item_frame      = o_fr;
  assign out_o.gameplay_frame  = o_gp;
  assign out_o.confirmed_frame = o_cf;
  assign out_o.confirm_ready   = o_cr;
  assign out_o.gameplay_ready  = o_gr;
  assign out_o.remote_missed   = o_rm;
  assign out_o.has_data        = o_hd;
  assign out_o.last            = o_last;

  assign sts_o.kind       = kind_q;
  assign sts_o.miss_done  = !miss_go;
  assign sts_o.first_cont = cont(kind_q, i_q, n_q, top, conf_q, lv_q[slot_of(i_q)]);
  assign sts_o.out_busy   = ov_q;
  assign sts_o.out_last   = o_last;

`ifndef SYNTHESIS
  a_remote_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q & ~rok_q) == '0) else $error("remote valid slot without data");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_RESULTS)) else $error("stream ran past its bound");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ov_q) else $error("emitted beat not shown");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !ov_q) else $error("beat emitted over a pending one");
`endif
endmodule

/* rtl/core/rollback_frame_input_ring_core.sv */
// top level of the rollback frame input ring
// Rollback frame input ring: one command per input beat, one result beat per streamed or read
// entry, otherwise one result beat, with last on the final one. An item is accepted in the idle
// cycle and executed in the next. The remote-missed walk then visits one slot per cycle over
// min(gameplay - confirmed - 1, RING_DEPTH) slots, then a closing step; no slot is walked
// when the confirmed frame can advance. A single result is then emitted. A stream makes a first
// check and then, per entry, a slot memory read and an emit step. Each result beat sits in the
// output register until it is taken, and the sequencer moves on in the cycle after it leaves, so
// a stalled output stalls the block. The next item is accepted once the last result beat of the
// current one has left.
module rollback_frame_input_ring_core import rfir_pkg::*; #(
  parameter int unsigned RING_DEPTH   = 16,
  parameter int unsigned INPUT_BITS   = 16,
  parameter int unsigned MISSED_BURST = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfir_in_if.sink    in_i,
  rfir_cfg_if.sink   cfg_i,
  rfir_out_if.source out_o
);
  cmd_t cmd;
  sts_t sts;

  rfir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfir_dp #(
    .RING_DEPTH   (RING_DEPTH),
    .INPUT_BITS   (INPUT_BITS),
    .MISSED_BURST (MISSED_BURST)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (in_i.kind),
    .frame_index_i (in_i.frame_index),
    .input_value_i (in_i.input_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg_i),
    .out_o         (out_o)
  );
endmodule

/* test/tb_ring_model.sv */
// scoreboard class: predicts the frame input ring and checks its result beats
package tb_ring_model_pkg;
  import rfir_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] local_value;
    logic [15:0] remote_value;
    logic [31:0] item_frame;
    logic [31:0] gameplay_frame;
    logic [31:0] confirmed_frame;
    logic        confirm_ready;
    logic        gameplay_ready;
    logic        remote_missed;
    logic        has_data;
    logic        last;
  } ring_result_t;

  class ring_scoreboard;
    localparam int DEPTH = 16;
    localparam int BURST = 10;
    bit          lvalid [DEPTH];
    bit          rvalid [DEPTH];
    bit [15:0]   lval [DEPTH];
    bit [15:0]   rval [DEPTH];
    bit [31:0]   cur, conf, hi_loc, hi_rem;
    bit [3:0]    rb_limit, delay;
    ring_result_t pending_q[$];
    int          mismatches;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        lvalid[i] = 0; rvalid[i] = 0; lval[i] = 0; rval[i] = 0;
      end
      cur = 0; conf = 0; hi_loc = 0; hi_rem = 0;
      rb_limit = ROLLBACK_RESET; delay = DELAY_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] d);
      if (idx == CFG_ROLLBACK_LIMIT) rb_limit = d;
      else if (idx == CFG_LOCAL_DELAY) delay = d;
    endfunction

    function bit [31:0] top();
      return (hi_rem > hi_loc) ? hi_rem : hi_loc;
    endfunction

    function bit in_range(bit [31:0] f);
      return f <= top() && f >= conf;
    endfunction

    function bit fvalid(bit [31:0] f);
      return in_range(f) && lvalid[f[3:0]] && rvalid[f[3:0]];
    endfunction

    function bit can_confirm();
      return fvalid(conf + 1) && conf < cur;
    endfunction

    function bit can_play();
      return {32'd0, cur} <= {32'd0, conf} + rb_limit && lvalid[cur[3:0]];
    endfunction

    function bit missed();
      longint unsigned n;
      bit [31:0] f;
      if (can_confirm() || cur <= conf) return 0;
      n = longint'(cur) - longint'(conf) - 1;
      if (n > DEPTH) n = DEPTH;
      for (longint unsigned i = 0; i < n; i++) begin
        f = conf + 1 + 32'(i);
        if (rvalid[f[3:0]]) return 1;
      end
      return 0;
    endfunction

    function void clear(bit [31:0] f);
      lvalid[f[3:0]] = 0; rvalid[f[3:0]] = 0; lval[f[3:0]] = 0; rval[f[3:0]] = 0;
    endfunction

    function ring_result_t mk(status_e st, bit [15:0] lv, bit [15:0] rv, bit [31:0] fr,
                              bit hd);
      ring_result_t r;
      r = '0;
      r.status = st; r.local_value = lv; r.remote_value = rv; r.item_frame = fr;
      r.has_data = hd;
      return r;
    endfunction

    function void note_item(kind_e kind, bit [31:0] fin, bit [15:0] v);
      ring_result_t res[$];
      bit [31:0] f, i;
      bit cr, gr, rm;
      f = fin;
      case (kind)
        KIND_INS_REMOTE, KIND_INS_LOCAL: begin
          if (kind == KIND_INS_LOCAL) f = cur + delay;
          if (!(f >= conf && (f - conf) < DEPTH)) res = {res, mk(ST_REJECT, 0, 0, 0, 0)};
          else begin
            if (kind == KIND_INS_REMOTE) begin
              if (f > hi_rem) begin
                if (f > top()) clear(f + 1);
                hi_rem = f;
              end
              rvalid[f[3:0]] = 1; rval[f[3:0]] = v;
            end else begin
              if (f > hi_loc) begin
                if (f > top()) clear(f + 1);
                hi_loc = f;
              end
              lvalid[f[3:0]] = 1; lval[f[3:0]] = v;
            end
            res = {res, mk(ST_DONE, 0, 0, 0, 0)};
          end
        end
        KIND_ADV_CONFIRM: begin
          if (fvalid(conf + 1)) begin
            conf++; res = {res, mk(ST_DONE, 0, 0, 0, 0)};
          end else res = {res, mk(ST_REFUSED, 0, 0, 0, 0)};
        end
        KIND_ADV_PLAY: begin
          if (can_play()) begin
            cur++; res = {res, mk(ST_DONE, 0, 0, 0, 0)};
          end else res = {res, mk(ST_REFUSED, 0, 0, 0, 0)};
        end
        KIND_READ:
          res = {res, mk(ST_DONE, lval[f[3:0]],
                         rvalid[f[3:0]] ? rval[f[3:0]] : rval[conf[3:0]], f, 1)};
        KIND_SEND_PEND: begin
          i = conf;
          while (res.size() < MAX_RESULTS && lvalid[i[3:0]]) begin
            res = {res, mk(ST_DONE, lval[i[3:0]], 0, i, 1)};
            i++;
            if (!in_range(i)) break;
          end
          if (res.size() == 0) res = {res, mk(ST_DONE, 0, 0, conf, 0)};
        end
        KIND_SEND_MISSED: begin
          i = f;
          while (res.size() < BURST && {32'd0, i} + DEPTH > {32'd0, top()} + 1 && i < top())
          begin
            if (!lvalid[i[3:0]]) break;
            res = {res, mk(ST_DONE, lval[i[3:0]], 0, i, 1)};
            i++;
            if (!(i <= top())) break;
          end
          if (res.size() == 0) res = {res, mk(ST_DONE, 0, 0, f, 0)};
        end
        default: begin
          for (int k = 0; k < delay; k++) lvalid[k % DEPTH] = 1;
          hi_loc = delay;
          res = {res, mk(ST_DONE, 0, 0, 0, 0)};
        end
      endcase
      cr = can_confirm(); gr = can_play(); rm = missed();
      foreach (res[k]) begin
        res[k].gameplay_frame = cur; res[k].confirmed_frame = conf;
        res[k].confirm_ready = cr; res[k].gameplay_ready = gr; res[k].remote_missed = rm;
        res[k].last = (k == res.size() - 1);
        pending_q = {pending_q, res[k]};
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
      end
    endfunction
  endclass
endpackage

/* test/tb_top.sv */
// top of the frame input ring testbench: stimulus, idling and final check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rfir_pkg::*;
  import tb_ring_model_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  rfir_in_if  in_ch();
  rfir_out_if out_ch();
  rfir_cfg_if cfg_ch();

  rollback_frame_input_ring_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .cfg_i(cfg_ch.sink),
    .out_o(out_ch.source)
  );

  ring_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;
  bit stall_on = 1;
  int burst_left = 0;

  initial begin
    in_ch.valid = 0; in_ch.kind = 0; in_ch.frame_index = 0; in_ch.input_value = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 0;
    else if (!stall_on) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      ring_result_t r;
      r.status = out_ch.status; r.local_value = out_ch.local_value;
      r.remote_value = out_ch.remote_value; r.item_frame = out_ch.item_frame;
      r.gameplay_frame = out_ch.gameplay_frame; r.confirmed_frame = out_ch.confirmed_frame;
      r.confirm_ready = out_ch.confirm_ready; r.gameplay_ready = out_ch.gameplay_ready;
      r.remote_missed = out_ch.remote_missed; r.has_data = out_ch.has_data;
      r.last = out_ch.last;
      sb.check_result(r);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(kind_e k, logic [31:0] f, logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1; in_ch.kind <= k; in_ch.frame_index <= f; in_ch.input_value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(k, f, v);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] d);
    drain();
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_ch.valid <= 0;
  endtask

  // mostly a well-formed game loop around the window, with some noise
  task automatic random_item();
    int p;
    logic [31:0] f;
    p = $urandom_range(0, 99);
    f = sb.conf + $urandom_range(0, 17);
    if (p < 5) f = $urandom();
    if (p < 22) send_item(KIND_INS_LOCAL, 0, 16'($urandom()));
    else if (p < 42) send_item(KIND_INS_REMOTE, f, 16'($urandom()));
    else if (p < 55) send_item(KIND_ADV_CONFIRM, $urandom(), 16'($urandom()));
    else if (p < 72) send_item(KIND_ADV_PLAY, $urandom(), 16'($urandom()));
    else if (p < 82) send_item(KIND_READ, f, 16'($urandom()));
    else if (p < 89) send_item(KIND_SEND_PEND, $urandom(), 16'($urandom()));
    else if (p < 96) send_item(KIND_SEND_MISSED, f - $urandom_range(0, 12), 16'($urandom()));
    else send_item(KIND_INIT_DELAY, $urandom(), 16'($urandom()));
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed
    send_item(KIND_READ, 32'd0, 16'hffff);
    send_item(KIND_SEND_PEND, 0, 0);
    send_item(KIND_SEND_MISSED, 0, 0);
    send_item(KIND_ADV_PLAY, 0, 0);
    send_item(KIND_ADV_CONFIRM, 0, 0);
    send_item(KIND_INIT_DELAY, 0, 0);
    send_item(KIND_INS_REMOTE, 32'hffff_ffff, 16'hffff);
    send_item(KIND_INS_REMOTE, 32'd16, 16'h1234);
    send_item(KIND_INS_REMOTE, 32'd15, 16'hffff);
    send_item(KIND_INS_REMOTE, 32'd1, 16'h0000);
    send_item(KIND_INS_LOCAL, 0, 16'hffff);
    send_item(KIND_ADV_PLAY, 0, 0);
    send_item(KIND_ADV_PLAY, 0, 0);
    send_item(KIND_ADV_CONFIRM, 0, 0);
    send_item(KIND_READ, 32'd14, 0);
    send_item(KIND_READ, 32'hffff_ffff, 0);
    send_item(KIND_SEND_PEND, 0, 0);
    send_item(KIND_SEND_MISSED, 32'd0, 0);
    send_item(KIND_SEND_MISSED, 32'hffff_ffff, 0);
    // several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ROLLBACK_LIMIT, 4'd0); write_reg(CFG_LOCAL_DELAY, 4'd0); end
        1: begin write_reg(CFG_ROLLBACK_LIMIT, 4'd15); write_reg(CFG_LOCAL_DELAY, 4'd15); end
        2: begin write_reg(CFG_ROLLBACK_LIMIT, 4'd7); write_reg(CFG_LOCAL_DELAY, 4'd2); end
        default: begin
          write_reg(CFG_ROLLBACK_LIMIT, 4'($urandom_range(0, 15)));
          write_reg(CFG_LOCAL_DELAY, 4'($urandom_range(0, 15)));
        end
      endcase
      stall_on = (ph != 2);
      if (ph == 3) fork
        begin hold_off = 1; repeat (400) @(negedge clk_i); hold_off = 0; end
      join_none
      for (int n = 0; n < 75; n++) random_item();
      if (ph == 4) drain();
    end
    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
